>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> sv/lcb_pkg.sv
// ----------------------------------------------------------------------------
// lcb_pkg
// Field widths, operation codes, register indexes, reset values and the limits type of the contact bucket.
// ----------------------------------------------------------------------------
package lcb_pkg;

  localparam int OP_W       = 3;
  localparam int ID_W       = 64;
  localparam int ADDR_W     = 48;
  localparam int FAIL_W     = 8;
  localparam int CNT_W      = 5;
  localparam int SCNT_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int LIM_W      = 8;

  localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd3;
  localparam logic [OP_W-1:0] OP_TOUCH  = 3'd4;
  localparam logic [OP_W-1:0] OP_DUMP   = 3'd5;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_CAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPL_LIMIT  = 2'd1;

  localparam logic [CNT_W-1:0]  CAP_RESET = 5'd20;
  localparam logic [SCNT_W-1:0] LIM_RESET = 4'd8;

  localparam logic [FAIL_W-1:0] FAIL_MAX = 8'hFF;

  // Effective limits after clamping into the supported ranges.
  typedef struct packed {
    logic [LIM_W-1:0] cap;
    logic [LIM_W-1:0] lim;
  } lcb_limits_t;

endpackage

>>> sv/lcb_cfg.sv
// ----------------------------------------------------------------------------
// lcb_cfg
// Configuration registers of the bucket and the clamping of their values.
// ----------------------------------------------------------------------------
module lcb_cfg #(
  parameter int MAX_CONTACTS = 20,
  parameter int MAX_SPARES   = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output lcb_pkg::lcb_limits_t           limits_o
);
  import lcb_pkg::*;

  logic [CNT_W-1:0]  cap_q, cap_d;
  logic [SCNT_W-1:0] lim_q, lim_d;
  logic [LIM_W-1:0]  cap_w, lim_w;

  always_comb begin
    cap_d = cap_q;
    lim_d = lim_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BUCKET_CAP: cap_d = cfg_wdata_i[CNT_W-1:0];
        REG_REPL_LIMIT: lim_d = cfg_wdata_i[SCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
      lim_q <= LIM_RESET;
    end else begin
      cap_q <= cap_d;
      lim_q <= lim_d;
    end
  end

  // A capacity of zero behaves as one; both limits saturate at the storage depth.
  always_comb begin
    cap_w = LIM_W'(cap_q);
    lim_w = LIM_W'(lim_q);
    if (cap_w == '0) begin
      limits_o.cap = LIM_W'(1);
    end else if (cap_w > LIM_W'(MAX_CONTACTS)) begin
      limits_o.cap = LIM_W'(MAX_CONTACTS);
    end else begin
      limits_o.cap = cap_w;
    end
    if (lim_w > LIM_W'(MAX_SPARES)) begin
      limits_o.lim = LIM_W'(MAX_SPARES);
    end else begin
      limits_o.lim = lim_w;
    end
  end

endmodule

>>> sv/lru_contact_bucket_with_replacements.sv
// ----------------------------------------------------------------------------
// lru_contact_bucket_with_replacements
// Recency-ordered contact bucket with a FIFO replacement cache, worked by a
// small sequencer over contact and spare memories with one read and one write port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                Payload
// command   in         start high, busy low     op_i, node_id_i, peer_address_i
// result    out        result_valid_o strobe    ok_o ... last_o
// config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// Each word walks the contacts one read per cycle: a find or mark scans the n
// contacts held, an add or touch that hits or a remove also shifts each later
// entry down by one place, and a dump emits one word per cycle.
// Each memory has a single read port and a separate write port.
// Reset clears the held counts and control state only; memory contents need no clearing pass.
// Results are strobed for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module lru_contact_bucket_with_replacements #(
  parameter int MAX_CONTACTS = 20,
  parameter int MAX_SPARES   = 8,
  parameter int ID_BITS      = 64,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we_i,
  input  logic [lcb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [lcb_pkg::OP_W-1:0]       op_i,
  input  logic [lcb_pkg::ID_W-1:0]       node_id_i,
  input  logic [lcb_pkg::ADDR_W-1:0]     peer_address_i,
  output logic                           result_valid_o,
  output logic                           ok_o,
  output logic [lcb_pkg::ID_W-1:0]       entry_id_o,
  output logic [lcb_pkg::ADDR_W-1:0]     entry_address_o,
  output logic [lcb_pkg::FAIL_W-1:0]     entry_fail_count_o,
  output logic                           oldest_valid_o,
  output logic [lcb_pkg::ID_W-1:0]       oldest_id_o,
  output logic [lcb_pkg::CNT_W-1:0]      contact_count_o,
  output logic [lcb_pkg::SCNT_W-1:0]     replacement_count_o,
  output logic                           last_o
);
  import lcb_pkg::*;

  localparam int CIW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
  localparam int SIW = (MAX_SPARES > 1) ? $clog2(MAX_SPARES) : 1;
  localparam int CCW = $clog2(MAX_CONTACTS + 1);
  localparam int SCW = $clog2(MAX_SPARES + 1);
  localparam int PW  = (CCW > SCW) ? CCW : SCW;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CSCAN  = 4'd1;
  localparam logic [3:0] ST_SSCAN  = 4'd2;
  localparam logic [3:0] ST_CSHIFT = 4'd3;
  localparam logic [3:0] ST_SSHIFT = 4'd4;
  localparam logic [3:0] ST_CPUSH  = 4'd5;
  localparam logic [3:0] ST_SPUSH  = 4'd6;
  localparam logic [3:0] ST_SUPD   = 4'd7;
  localparam logic [3:0] ST_SHEAD  = 4'd8;
  localparam logic [3:0] ST_SHEADW = 4'd9;
  localparam logic [3:0] ST_MARK   = 4'd10;
  localparam logic [3:0] ST_RESULT = 4'd11;
  localparam logic [3:0] ST_DUMP   = 4'd12;

  lcb_limits_t limits;

  lcb_cfg #(
    .MAX_CONTACTS (MAX_CONTACTS),
    .MAX_SPARES   (MAX_SPARES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .limits_o    (limits)
  );

  // Control state
  logic [3:0]          state_q, state_d;
  logic [CCW-1:0]      c_held_q, c_held_d;
  logic [SCW-1:0]      s_held_q, s_held_d;
  logic [PW-1:0]       ptr_q, ptr_d;
  logic [PW-1:0]       pidx_q, pidx_d;
  logic                pend_q, pend_d;
  logic                res_valid_q;

  // Payload registers
  logic [OP_W-1:0]         op_q, op_d;
  logic [ID_BITS-1:0]      id_q, id_d;
  logic [ADDRESS_BITS-1:0] addr_q, addr_d;
  logic [PW-1:0]           k_q, k_d;
  logic                    ok_q, ok_d;
  logic [ID_BITS-1:0]      ent_id_q, ent_id_d;
  logic [ADDRESS_BITS-1:0] ent_addr_q, ent_addr_d;
  logic [FAIL_W-1:0]       ent_fail_q, ent_fail_d;
  logic [ID_BITS-1:0]      push_id_q, push_id_d;
  logic [ADDRESS_BITS-1:0] push_addr_q, push_addr_d;
  logic [ID_BITS-1:0]      oldest_q, oldest_d;

  // Output registers
  logic                    res_ok_q, res_last_q, res_ovalid_q;
  logic [ID_W-1:0]         res_id_q, res_oid_q;
  logic [ADDR_W-1:0]       res_addr_q;
  logic [FAIL_W-1:0]       res_fail_q;
  logic [CNT_W-1:0]        res_cnt_q;
  logic [SCNT_W-1:0]       res_scnt_q;

  // Emit request
  logic                    emit, e_ok, e_last;
  logic [ID_BITS-1:0]      e_id;
  logic [ADDRESS_BITS-1:0] e_addr;
  logic [FAIL_W-1:0]       e_fail;

  // Contact memory
  logic [ID_BITS-1:0]      c_id_mem   [MAX_CONTACTS];
  logic [ADDRESS_BITS-1:0] c_addr_mem [MAX_CONTACTS];
  logic [FAIL_W-1:0]       c_fail_mem [MAX_CONTACTS];
  logic                    c_re, c_we;
  logic [CIW-1:0]          c_raddr, c_waddr;
  logic [ID_BITS-1:0]      c_wid, c_rd_id_q;
  logic [ADDRESS_BITS-1:0] c_waddr_val, c_rd_addr_q;
  logic [FAIL_W-1:0]       c_wfail, c_rd_fail_q;

  // Spare memory
  logic [ID_BITS-1:0]      s_id_mem   [MAX_SPARES];
  logic [ADDRESS_BITS-1:0] s_addr_mem [MAX_SPARES];
  logic                    s_re, s_we;
  logic [SIW-1:0]          s_raddr, s_waddr;
  logic [ID_BITS-1:0]      s_wid, s_rd_id_q;
  logic [ADDRESS_BITS-1:0] s_waddr_val, s_rd_addr_q;

  logic [PW-1:0] c_held_p, s_held_p, pidx_m1, ptr_p1, pidx_p1;
  logic          c_hit, s_hit, has_room, s_full, lim_zero, dump_last;

  assign busy     = (state_q != ST_IDLE);
  assign c_held_p = PW'(c_held_q);
  assign s_held_p = PW'(s_held_q);
  assign pidx_m1  = pidx_q - 1'b1;
  assign pidx_p1  = pidx_q + 1'b1;
  assign ptr_p1   = ptr_q + 1'b1;
  assign c_hit    = pend_q && (c_rd_id_q == id_q);
  assign s_hit    = pend_q && (s_rd_id_q == id_q);
  assign has_room = LIM_W'(c_held_q) < limits.cap;
  assign s_full   = LIM_W'(s_held_q) >= limits.lim;
  assign lim_zero = (limits.lim == '0);
  assign dump_last = (pidx_q == c_held_p - 1'b1);

  always_comb begin
    state_d     = state_q;
    c_held_d    = c_held_q;
    s_held_d    = s_held_q;
    ptr_d       = ptr_q;
    pidx_d      = pidx_q;
    pend_d      = pend_q;
    op_d        = op_q;
    id_d        = id_q;
    addr_d      = addr_q;
    k_d         = k_q;
    ok_d        = ok_q;
    ent_id_d    = ent_id_q;
    ent_addr_d  = ent_addr_q;
    ent_fail_d  = ent_fail_q;
    push_id_d   = push_id_q;
    push_addr_d = push_addr_q;
    oldest_d    = oldest_q;

    emit   = 1'b0;
    e_ok   = ok_q;
    e_last = 1'b1;
    e_id   = ent_id_q;
    e_addr = ent_addr_q;
    e_fail = ent_fail_q;

    c_re        = 1'b0;
    c_raddr     = ptr_q[CIW-1:0];
    c_we        = 1'b0;
    c_waddr     = pidx_m1[CIW-1:0];
    c_wid       = c_rd_id_q;
    c_waddr_val = c_rd_addr_q;
    c_wfail     = c_rd_fail_q;
    s_re        = 1'b0;
    s_raddr     = ptr_q[SIW-1:0];
    s_we        = 1'b0;
    s_waddr     = pidx_m1[SIW-1:0];
    s_wid       = s_rd_id_q;
    s_waddr_val = s_rd_addr_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d       = op_i;
          id_d       = node_id_i[ID_BITS-1:0];
          addr_d     = peer_address_i[ADDRESS_BITS-1:0];
          ptr_d      = '0;
          pend_d     = 1'b0;
          ok_d       = 1'b0;
          ent_id_d   = '0;
          ent_addr_d = '0;
          ent_fail_d = '0;
          case (op_i)
            OP_ADD, OP_REMOVE, OP_FIND, OP_MARK, OP_TOUCH: state_d = ST_CSCAN;
            OP_DUMP: state_d = (c_held_q == '0) ? ST_RESULT : ST_DUMP;
            OP_CLEAR: begin
              c_held_d = '0;
              s_held_d = '0;
              ok_d     = 1'b1;
              state_d  = ST_RESULT;
            end
            default: state_d = ST_RESULT;
          endcase
        end
      end

      ST_CSCAN: begin
        if (c_hit) begin
          k_d    = pidx_q;
          ptr_d  = pidx_p1;
          pend_d = 1'b0;
          ok_d   = 1'b1;
          case (op_q)
            OP_ADD: begin
              push_id_d   = id_q;
              push_addr_d = addr_q;
              state_d     = ST_CSHIFT;
            end
            OP_REMOVE: state_d = ST_CSHIFT;
            OP_FIND: begin
              ent_id_d   = c_rd_id_q;
              ent_addr_d = c_rd_addr_q;
              ent_fail_d = c_rd_fail_q;
              state_d    = ST_RESULT;
            end
            OP_MARK: begin
              ent_id_d   = c_rd_id_q;
              ent_addr_d = c_rd_addr_q;
              ent_fail_d = (c_rd_fail_q == FAIL_MAX) ? FAIL_MAX : c_rd_fail_q + 1'b1;
              state_d    = ST_MARK;
            end
            OP_TOUCH: begin
              ent_id_d    = c_rd_id_q;
              ent_addr_d  = c_rd_addr_q;
              ent_fail_d  = '0;
              push_id_d   = c_rd_id_q;
              push_addr_d = c_rd_addr_q;
              state_d     = ST_CSHIFT;
            end
            default: state_d = ST_RESULT;
          endcase
        end else if (ptr_q < c_held_p) begin
          c_re   = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_p1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          // No contact carries the id.
          ptr_d = '0;
          case (op_q)
            OP_ADD: begin
              if (has_room) begin
                push_id_d   = id_q;
                push_addr_d = addr_q;
                ok_d        = 1'b1;
                state_d     = ST_CPUSH;
              end else begin
                state_d = ST_SSCAN;
              end
            end
            OP_REMOVE: state_d = ST_SSCAN;
            default:   state_d = ST_RESULT;
          endcase
        end
      end

      ST_SSCAN: begin
        if (s_hit) begin
          k_d    = pidx_q;
          ptr_d  = pidx_p1;
          pend_d = 1'b0;
          case (op_q)
            OP_ADD: state_d = ST_SUPD;
            OP_REMOVE: begin
              ok_d    = 1'b1;
              state_d = ST_SSHIFT;
            end
            default: state_d = ST_RESULT;
          endcase
        end else if (ptr_q < s_held_p) begin
          s_re   = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_p1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          if (op_q == OP_ADD && !lim_zero) begin
            if (s_full) begin
              // Make room by dropping the oldest cached candidate.
              ptr_d   = PW'(1);
              state_d = ST_SSHIFT;
            end else begin
              state_d = ST_SPUSH;
            end
          end else begin
            state_d = ST_RESULT;
          end
        end
      end

      ST_CSHIFT: begin
        // Entry pidx moves down to pidx - 1 while the next one is read.
        if (pend_q) begin
          c_we = 1'b1;
        end
        if (ptr_q < c_held_p) begin
          c_re   = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_p1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            c_held_d = c_held_q - 1'b1;
            case (op_q)
              OP_ADD, OP_TOUCH: state_d = ST_CPUSH;
              OP_REMOVE: state_d = (s_held_q != '0) ? ST_SHEAD : ST_RESULT;
              default: state_d = ST_RESULT;
            endcase
          end
        end
      end

      ST_SSHIFT: begin
        if (pend_q) begin
          s_we = 1'b1;
        end
        if (ptr_q < s_held_p) begin
          s_re   = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_p1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            s_held_d = s_held_q - 1'b1;
            state_d  = (op_q == OP_ADD) ? ST_SPUSH : ST_RESULT;
          end
        end
      end

      ST_SHEAD: begin
        s_re    = 1'b1;
        s_raddr = '0;
        state_d = ST_SHEADW;
      end

      ST_SHEADW: begin
        push_id_d   = s_rd_id_q;
        push_addr_d = s_rd_addr_q;
        state_d     = ST_CPUSH;
      end

      ST_CPUSH: begin
        c_we        = 1'b1;
        c_waddr     = c_held_q[CIW-1:0];
        c_wid       = push_id_q;
        c_waddr_val = push_addr_q;
        c_wfail     = '0;
        c_held_d    = c_held_q + 1'b1;
        if (op_q == OP_REMOVE) begin
          // The promoted head leaves the cache.
          ptr_d   = PW'(1);
          pend_d  = 1'b0;
          state_d = ST_SSHIFT;
        end else begin
          state_d = ST_RESULT;
        end
      end

      ST_SPUSH: begin
        s_we        = 1'b1;
        s_waddr     = s_held_q[SIW-1:0];
        s_wid       = id_q;
        s_waddr_val = addr_q;
        s_held_d    = s_held_q + 1'b1;
        state_d     = ST_RESULT;
      end

      ST_SUPD: begin
        s_we        = 1'b1;
        s_waddr     = k_q[SIW-1:0];
        s_wid       = id_q;
        s_waddr_val = addr_q;
        state_d     = ST_RESULT;
      end

      ST_MARK: begin
        c_we        = 1'b1;
        c_waddr     = k_q[CIW-1:0];
        c_wid       = ent_id_q;
        c_waddr_val = ent_addr_q;
        c_wfail     = ent_fail_q;
        state_d     = ST_RESULT;
      end

      ST_RESULT: begin
        emit    = 1'b1;
        state_d = ST_IDLE;
      end

      ST_DUMP: begin
        if (pend_q) begin
          emit   = 1'b1;
          e_ok   = 1'b1;
          e_last = dump_last;
          e_id   = c_rd_id_q;
          e_addr = c_rd_addr_q;
          e_fail = c_rd_fail_q;
        end
        if (ptr_q < c_held_p) begin
          c_re   = 1'b1;
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_p1;
        end else begin
          pend_d = 1'b0;
          if (pend_q) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase

    // The oldest id follows every write into the head slot.
    if (c_we && c_waddr == '0) begin
      oldest_d = c_wid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      c_held_q    <= '0;
      s_held_q    <= '0;
      ptr_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      c_held_q    <= c_held_d;
      s_held_q    <= s_held_d;
      ptr_q       <= ptr_d;
      pidx_q      <= pidx_d;
      pend_q      <= pend_d;
      res_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    id_q        <= id_d;
    addr_q      <= addr_d;
    k_q         <= k_d;
    ok_q        <= ok_d;
    ent_id_q    <= ent_id_d;
    ent_addr_q  <= ent_addr_d;
    ent_fail_q  <= ent_fail_d;
    push_id_q   <= push_id_d;
    push_addr_q <= push_addr_d;
    oldest_q    <= oldest_d;
    if (emit) begin
      res_ok_q     <= e_ok;
      res_last_q   <= e_last;
      res_id_q     <= ID_W'(e_id);
      res_addr_q   <= ADDR_W'(e_addr);
      res_fail_q   <= e_fail;
      res_ovalid_q <= (c_held_q != '0);
      res_oid_q    <= (c_held_q != '0) ? ID_W'(oldest_q) : '0;
      res_cnt_q    <= CNT_W'(c_held_q);
      res_scnt_q   <= SCNT_W'(s_held_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_id_mem[c_waddr]   <= c_wid;
      c_addr_mem[c_waddr] <= c_waddr_val;
      c_fail_mem[c_waddr] <= c_wfail;
    end
    if (c_re) begin
      c_rd_id_q   <= c_id_mem[c_raddr];
      c_rd_addr_q <= c_addr_mem[c_raddr];
      c_rd_fail_q <= c_fail_mem[c_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_id_mem[s_waddr]   <= s_wid;
      s_addr_mem[s_waddr] <= s_waddr_val;
    end
    if (s_re) begin
      s_rd_id_q   <= s_id_mem[s_raddr];
      s_rd_addr_q <= s_addr_mem[s_raddr];
    end
  end

  assign result_valid_o      = res_valid_q;
  assign ok_o                = res_ok_q;
  assign entry_id_o          = res_id_q;
  assign entry_address_o     = res_addr_q;
  assign entry_fail_count_o  = res_fail_q;
  assign oldest_valid_o      = res_ovalid_q;
  assign oldest_id_o         = res_oid_q;
  assign contact_count_o     = res_cnt_q;
  assign replacement_count_o = res_scnt_q;
  assign last_o              = res_last_q;

  `include "assert_macros.svh"

  `ASSERT_NEVER(a_contacts_bounded, c_held_q > CCW'(MAX_CONTACTS), "contact count overflow")
  `ASSERT_NEVER(a_spares_bounded, s_held_q > SCW'(MAX_SPARES), "spare count overflow")
  `ASSERT_CLK(a_accept_busy, start && !busy |=> busy, "accepted word left sequencer idle")
  `ASSERT_CLK(a_last_idle, result_valid_o && last_o |-> !busy, "busy after final result")
  `ASSERT_CLK(a_more_busy, result_valid_o && !last_o |-> busy, "idle before final result")

endmodule

>>> bench/tb_lru_contact_bucket_with_replacements.sv
// ----------------------------------------------------------------------------
// tb_lru_contact_bucket_with_replacements
// Self-checking bench for the recency-ordered contact bucket. A queue of
// commands feeds a clocked driver. The driver updates a behavioral copy of the
// bucket and its replacement cache for every accepted command. A clocked
// monitor compares each strobed result word field by field against that copy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lru_contact_bucket_with_replacements;
  import lcb_pkg::*;

  localparam int NUM_SLOTS  = 20;
  localparam int NUM_SPARES = 8;
  localparam int SETTLE_CYCLES = 8;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 3'd7;

  localparam logic [ID_W-1:0] ID_A = 64'h0123_4567_89AB_CDEF;
  localparam logic [ID_W-1:0] ID_B = 64'hFEDC_BA98_7654_3210;
  localparam logic [ID_W-1:0] ID_C = 64'h8000_0000_0000_0001;
  localparam logic [ID_W-1:0] ID_D = 64'h5A5A_A5A5_5A5A_A5A5;
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   id;
    logic [ADDR_W-1:0] addr;
  } bucket_cmd_t;

  typedef struct {
    logic              ok;
    logic [ID_W-1:0]   entry_id;
    logic [ADDR_W-1:0] entry_addr;
    logic [FAIL_W-1:0] entry_fails;
    logic              oldest_valid;
    logic [ID_W-1:0]   oldest_id;
    logic [CNT_W-1:0]  contact_cnt;
    logic [SCNT_W-1:0] spare_cnt;
    logic              last;
  } bucket_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic [OP_W-1:0] op_i = '0;
  logic [ID_W-1:0] node_id_i = '0;
  logic [ADDR_W-1:0] peer_address_i = '0;
  logic result_valid_o;
  logic ok_o;
  logic [ID_W-1:0] entry_id_o;
  logic [ADDR_W-1:0] entry_address_o;
  logic [FAIL_W-1:0] entry_fail_count_o;
  logic oldest_valid_o;
  logic [ID_W-1:0] oldest_id_o;
  logic [CNT_W-1:0] contact_count_o;
  logic [SCNT_W-1:0] replacement_count_o;
  logic last_o;

  // Behavioral copy of the bucket, oldest contact at index 0.
  logic [ID_W-1:0]   slot_id    [NUM_SLOTS];
  logic [ADDR_W-1:0] slot_addr  [NUM_SLOTS];
  logic [FAIL_W-1:0] slot_fails [NUM_SLOTS];
  int                slots_held = 0;
  logic [ID_W-1:0]   spare_id   [NUM_SPARES];
  logic [ADDR_W-1:0] spare_addr [NUM_SPARES];
  int                spares_held = 0;
  logic [CNT_W-1:0]  cap_reg = CAP_RESET;
  logic [SCNT_W-1:0] lim_reg = LIM_RESET;

  bucket_cmd_t   cmd_q[$];
  bucket_reply_t reply_q[$];
  logic [ID_W-1:0] id_pool[16];
  int idle_pct = 0;
  int mismatch_count = 0;

  lru_contact_bucket_with_replacements u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .op_i                (op_i),
    .node_id_i           (node_id_i),
    .peer_address_i      (peer_address_i),
    .result_valid_o      (result_valid_o),
    .ok_o                (ok_o),
    .entry_id_o          (entry_id_o),
    .entry_address_o     (entry_address_o),
    .entry_fail_count_o  (entry_fail_count_o),
    .oldest_valid_o      (oldest_valid_o),
    .oldest_id_o         (oldest_id_o),
    .contact_count_o     (contact_count_o),
    .replacement_count_o (replacement_count_o),
    .last_o              (last_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bucket behavior
  // --------------------------------------------------------------------------
  function automatic int slot_index(logic [ID_W-1:0] id);
    for (int i = 0; i < slots_held; i++) begin
      if (slot_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int spare_index(logic [ID_W-1:0] id);
    for (int i = 0; i < spares_held; i++) begin
      if (spare_id[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int k);
    for (int i = k; i + 1 < slots_held; i++) begin
      slot_id[i]    = slot_id[i+1];
      slot_addr[i]  = slot_addr[i+1];
      slot_fails[i] = slot_fails[i+1];
    end
    slots_held--;
  endfunction

  function automatic void drop_spare(int k);
    for (int i = k; i + 1 < spares_held; i++) begin
      spare_id[i]   = spare_id[i+1];
      spare_addr[i] = spare_addr[i+1];
    end
    spares_held--;
  endfunction

  function automatic void append_slot(logic [ID_W-1:0] id, logic [ADDR_W-1:0] addr);
    slot_id[slots_held]    = id;
    slot_addr[slots_held]  = addr;
    slot_fails[slots_held] = '0;
    slots_held++;
  endfunction

  // Moves contact k to the newest end with its fail count cleared.
  function automatic void refresh_slot(int k, logic [ADDR_W-1:0] addr);
    logic [ID_W-1:0] id;
    id = slot_id[k];
    drop_slot(k);
    append_slot(id, addr);
  endfunction

  function automatic bucket_reply_t reply_word(logic ok, logic [ID_W-1:0] id,
                                               logic [ADDR_W-1:0] addr,
                                               logic [FAIL_W-1:0] fails, logic last);
    bucket_reply_t r;
    r.ok           = ok;
    r.entry_id     = id;
    r.entry_addr   = addr;
    r.entry_fails  = fails;
    r.oldest_valid = (slots_held > 0);
    r.oldest_id    = (slots_held > 0) ? slot_id[0] : '0;
    r.contact_cnt  = CNT_W'(slots_held);
    r.spare_cnt    = SCNT_W'(spares_held);
    r.last         = last;
    return r;
  endfunction

  function automatic void bucket_step(bucket_cmd_t c);
    int k;
    int cap;
    int lim;
    logic ok;
    logic [ID_W-1:0] eid;
    logic [ADDR_W-1:0] eaddr;
    logic [FAIL_W-1:0] efail;
    ok = 1'b0;
    eid = '0;
    eaddr = '0;
    efail = '0;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > NUM_SLOTS) ? NUM_SLOTS : int'(cap_reg));
    lim = (lim_reg > NUM_SPARES) ? NUM_SPARES : int'(lim_reg);
    case (c.op)
      OP_ADD: begin
        k = slot_index(c.id);
        if (k >= 0) begin
          refresh_slot(k, c.addr);
          ok = 1'b1;
        end else if (slots_held < cap) begin
          append_slot(c.id, c.addr);
          ok = 1'b1;
        end else begin
          k = spare_index(c.id);
          if (k >= 0) begin
            spare_addr[k] = c.addr;
          end else if (lim > 0) begin
            if (spares_held >= lim && spares_held > 0) drop_spare(0);
            if (spares_held < NUM_SPARES) begin
              spare_id[spares_held]   = c.id;
              spare_addr[spares_held] = c.addr;
              spares_held++;
            end
          end
        end
      end
      OP_REMOVE: begin
        k = slot_index(c.id);
        if (k >= 0) begin
          drop_slot(k);
          // The cache head takes the freed place at the newest end.
          if (spares_held > 0) begin
            append_slot(spare_id[0], spare_addr[0]);
            drop_spare(0);
          end
          ok = 1'b1;
        end else begin
          k = spare_index(c.id);
          if (k >= 0) begin
            drop_spare(k);
            ok = 1'b1;
          end
        end
      end
      OP_FIND, OP_MARK, OP_TOUCH: begin
        k = slot_index(c.id);
        if (k >= 0) begin
          if (c.op == OP_MARK) begin
            if (slot_fails[k] != FAIL_MAX) slot_fails[k] = slot_fails[k] + 1'b1;
          end else if (c.op == OP_TOUCH) begin
            refresh_slot(k, slot_addr[k]);
            k = slots_held - 1;
          end
          ok = 1'b1;
          eid = slot_id[k];
          eaddr = slot_addr[k];
          efail = slot_fails[k];
        end
      end
      OP_DUMP: begin
        if (slots_held > 0) begin
          for (int i = 0; i < slots_held; i++) begin
            reply_q.insert(reply_q.size(),
                           reply_word(1'b1, slot_id[i], slot_addr[i], slot_fails[i],
                                      i == slots_held - 1));
          end
          return;
        end
      end
      OP_CLEAR: begin
        slots_held = 0;
        spares_held = 0;
        ok = 1'b1;
      end
      default: begin
      end
    endcase
    reply_q.insert(reply_q.size(), reply_word(ok, eid, eaddr, efail, 1'b1));
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents queued commands, holds each until busy is low.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    bucket_cmd_t c;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && busy === 1'b0) begin
        c.op = op_i;
        c.id = node_id_i;
        c.addr = peer_address_i;
        bucket_step(c);
      end
      if (start && busy !== 1'b0) begin
        // Word not taken yet; keep it on the ports.
      end else if ($urandom_range(99) < idle_pct) begin
        start <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        c = cmd_q[0];
        cmd_q.delete(0);
        start <= 1'b1;
        op_i <= c.op;
        node_id_i <= c.id;
        peer_address_i <= c.addr;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    bucket_reply_t r;
    if (rst_ni && result_valid_o === 1'b1) begin
      if (reply_q.size() == 0) begin
        $error("result word with none outstanding");
        mismatch_count++;
      end else begin
        r = reply_q[0];
        reply_q.delete(0);
        check_field("ok", 64'(r.ok), 64'(ok_o));
        check_field("entry_id", r.entry_id, entry_id_o);
        check_field("entry_address", 64'(r.entry_addr), 64'(entry_address_o));
        check_field("entry_fail_count", 64'(r.entry_fails), 64'(entry_fail_count_o));
        check_field("oldest_valid", 64'(r.oldest_valid), 64'(oldest_valid_o));
        check_field("oldest_id", r.oldest_id, oldest_id_o);
        check_field("contact_count", 64'(r.contact_cnt), 64'(contact_count_o));
        check_field("replacement_count", 64'(r.spare_cnt), 64'(replacement_count_o));
        check_field("last", 64'(r.last), 64'(last_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic add_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                         logic [ADDR_W-1:0] addr = '0);
    bucket_cmd_t c;
    c.op = op;
    c.id = id;
    c.addr = addr;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // Returns once every queued word is taken and every result has come back.
  task automatic drain();
    while (cmd_q.size() != 0 || start || reply_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    if (idx == REG_BUCKET_CAP) cap_reg = val[CNT_W-1:0];
    else if (idx == REG_REPL_LIMIT) lim_reg = val[SCNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly ids from a small pool so that hits, full buckets and cache traffic
  // are common; the rest are fresh random ids.
  function automatic bucket_cmd_t random_cmd();
    bucket_cmd_t c;
    logic [63:0] raw;
    int r;
    r = $urandom_range(99);
    if (r < 35) c.op = OP_ADD;
    else if (r < 50) c.op = OP_REMOVE;
    else if (r < 62) c.op = OP_FIND;
    else if (r < 74) c.op = OP_MARK;
    else if (r < 86) c.op = OP_TOUCH;
    else if (r < 94) c.op = OP_DUMP;
    else if (r < 96) c.op = OP_CLEAR;
    else c.op = OP_UNKNOWN;
    if ($urandom_range(99) < 80) c.id = id_pool[$urandom_range(15)];
    else c.id = {$urandom(), $urandom()};
    r = $urandom_range(9);
    raw = {$urandom(), $urandom()};
    c.addr = (r == 0) ? '0 : ((r == 1) ? ADDR_ONES : raw[ADDR_W-1:0]);
    return c;
  endfunction

  initial begin
    logic [CFG_DATA_W-1:0] phase_cap [8];
    logic [CFG_DATA_W-1:0] phase_lim [8];
    int phase_idle [4];

    phase_cap = '{5'd20, 5'd31, 5'd3, 5'd1, 5'd5, 5'd20, 5'd0, 5'd12};
    phase_lim = '{5'd8, 5'd15, 5'd2, 5'd0, 5'd8, 5'd0, 5'd1, 5'd4};
    phase_idle = '{0, 71, 0, 24};

    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = ID_A;
    id_pool[3] = ID_B;
    for (int i = 4; i < 16; i++) id_pool[i] = {$urandom(), $urandom()};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Basic operations at the reset limits, extremes of the fields.
    add_cmd(OP_DUMP, '0);
    add_cmd(OP_FIND, ID_A);
    add_cmd(OP_UNKNOWN, ID_A, ADDR_ONES);
    add_cmd(OP_ADD, '0, '0);
    add_cmd(OP_ADD, '1, ADDR_ONES);
    add_cmd(OP_ADD, '0, 48'h1234_5678_9ABC);
    add_cmd(OP_MARK, '1);
    add_cmd(OP_TOUCH, '0);
    add_cmd(OP_FIND, '1);
    add_cmd(OP_DUMP, '0);
    add_cmd(OP_REMOVE, '1);
    add_cmd(OP_REMOVE, '1);
    add_cmd(OP_CLEAR, '0);
    drain();

    // A capacity of zero acts as one; single cache slot.
    write_reg(REG_BUCKET_CAP, 5'd0);
    write_reg(REG_REPL_LIMIT, 5'd1);
    add_cmd(OP_ADD, ID_A, 48'h0000_0000_00A1);
    add_cmd(OP_ADD, ID_B, 48'h0000_0000_00B1);
    add_cmd(OP_ADD, ID_C, 48'h0000_0000_00C1);
    add_cmd(OP_ADD, ID_C, 48'h0000_0000_00C2);
    add_cmd(OP_REMOVE, ID_A);
    add_cmd(OP_ADD, ID_D, 48'h0000_0000_00D1);
    add_cmd(OP_REMOVE, ID_D);
    add_cmd(OP_DUMP, '0);
    add_cmd(OP_CLEAR, '0);
    drain();

    // A cached id that also enters the bucket comes back as a duplicate on
    // promotion; operations then act on the oldest copy.
    write_reg(REG_BUCKET_CAP, 5'd1);
    write_reg(REG_REPL_LIMIT, 5'd2);
    add_cmd(OP_ADD, ID_A, 48'h0000_0000_0A00);
    add_cmd(OP_ADD, ID_B, 48'h0000_0000_0B00);
    drain();
    write_reg(REG_BUCKET_CAP, 5'd2);
    add_cmd(OP_ADD, ID_B, 48'h0000_0000_0B01);
    add_cmd(OP_REMOVE, ID_A);
    add_cmd(OP_MARK, ID_B);
    add_cmd(OP_DUMP, '0);
    add_cmd(OP_REMOVE, ID_B);
    add_cmd(OP_DUMP, '0);

    // Fail count saturation.
    add_cmd(OP_CLEAR, '0);
    add_cmd(OP_ADD, ID_C, ADDR_ONES);
    for (int i = 0; i < 258; i++) add_cmd(OP_MARK, ID_C);
    add_cmd(OP_FIND, ID_C);
    drain();

    // Random phases. Limits change without a clear in between, so they also
    // drop below what is already held.
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_BUCKET_CAP, phase_cap[p]);
      write_reg(REG_REPL_LIMIT, phase_lim[p]);
      idle_pct = phase_idle[p % 4];
      for (int i = 0; i < 4; i++) id_pool[4 + $urandom_range(11)] = {$urandom(), $urandom()};
      for (int i = 0; i < 14; i++) cmd_q.insert(cmd_q.size(), random_cmd());
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
